[hdl/nrcw_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package nrcw_pkg;

	localparam int TIME_BITS_DEF = 48;

	localparam int MD_W  = 16;
	localparam int MW_W  = 18;
	localparam int CNT_W = 32;
	localparam int CFG_W = 18;
	localparam int IDX_W = 2;

	localparam logic [MD_W-1:0]  MD_RESET    = 16'd1200;
	localparam logic [MW_W-1:0]  MW_RESET    = 18'd2400;
	localparam logic [CNT_W-1:0] WIN_RESET   = 32'd12000;
	localparam logic [CNT_W-1:0] INIT_DGRAMS = 32'd10;

	localparam int DIV_STEPS = CNT_W;
	localparam int STEP_W    = $clog2(DIV_STEPS);

	typedef enum logic [IDX_W-1:0] {
		REG_DGRAM_SIZE = 2'd0,
		REG_WIN_FLOOR  = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SENT    = 2'd0,
		MODE_ACKED   = 2'd1,
		MODE_LOST    = 2'd2,
		MODE_PERSIST = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_DIV,
		ST_ADD,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic step;
		logic grow;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_div;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

[hdl/newreno_congestion_window_top.sv]
// NewReno congestion window controller.
// Input channel (in_valid/in_stall) carries one event per item: mode, bytes,
// sent_time and now_time. Output channel (out_valid/out_stall) carries one
// result item per event: window, slow start threshold, bytes in flight and
// the recovery flag, all as they stand after the event.
// Configuration: wr_en/wr_index/wr_data write the datagram size (index 0, also
// sets the window to ten datagrams) or the window floor (index 1); other
// indexes are ignored. Write only while no event is in progress.
// An event is taken in IDLE and applied in EXEC, and its result is
// registered in EMIT; an ack in congestion avoidance first runs the 32-step
// restoring divide of datagram size times bytes by the window, then ADD.
// A new event is taken only after the previous result has been emitted.
// The output register lets the next event be processed while a result waits;
// a stalled result holds, and a finished event then waits for the register
// to empty, with in_stall high.
// Reset: window 12000, threshold infinite, nothing in flight, not recovering,
// datagram size 1200, window floor 2400.
`timescale 1ns / 1ps
`default_nettype none
module newreno_congestion_window_top
	import nrcw_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [1:0]           mode,
	input  wire logic [15:0]          bytes,
	input  wire logic [TIME_BITS-1:0] sent_time,
	input  wire logic [TIME_BITS-1:0] now_time,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [CNT_W-1:0]          window_bytes,
	output logic [CNT_W-1:0]          threshold_bytes,
	output logic [CNT_W-1:0]          in_flight_bytes,
	output logic                      recovering
);

	cmd_t cmd;
	sts_t sts;

	nrcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	nrcw_dp #(
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.mode            (mode),
		.bytes           (bytes),
		.sent_time       (sent_time),
		.now_time        (now_time),
		.out_stall       (out_stall),
		.out_valid       (out_valid),
		.window_bytes    (window_bytes),
		.threshold_bytes (threshold_bytes),
		.in_flight_bytes (in_flight_bytes),
		.recovering      (recovering)
	);

	// the block is busy in the cycle after it accepts an item
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("block not busy after accepting an item");

	// a new result only comes out of a busy block
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared without an item in progress");

	// recovery only follows a loss, which makes the threshold finite
	a_recovery_finite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && recovering |-> threshold_bytes != '1)
		else $error("recovering with an infinite threshold");

endmodule
`default_nettype wire

[hdl/nrcw_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none
module nrcw_ctrl
	import nrcw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire sts_t sts,
	output cmd_t      cmd,
	output logic      in_stall
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				step_q <= '0;
			end else if (cmd.step) begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = sts.need_div ? ST_DIV : ST_EMIT;
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (step_q == STEP_W'(DIV_STEPS - 1)) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				cmd.grow = 1'b1;
				state_d  = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[hdl/nrcw_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
module nrcw_dp
	import nrcw_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 cmd,
	output sts_t                      sts,
	input  wire logic                 wr_en,
	input  wire logic [IDX_W-1:0]     wr_index,
	input  wire logic [CFG_W-1:0]     wr_data,
	input  wire logic [1:0]           mode,
	input  wire logic [15:0]          bytes,
	input  wire logic [TIME_BITS-1:0] sent_time,
	input  wire logic [TIME_BITS-1:0] now_time,
	input  wire logic                 out_stall,
	output logic                      out_valid,
	output logic [CNT_W-1:0]          window_bytes,
	output logic [CNT_W-1:0]          threshold_bytes,
	output logic [CNT_W-1:0]          in_flight_bytes,
	output logic                      recovering
);

	// configuration and congestion state
	logic [MD_W-1:0]      md_q;
	logic [MW_W-1:0]      min_q;
	logic [CNT_W-1:0]     win_q;
	logic [CNT_W-1:0]     lim_q;
	logic [CNT_W-1:0]     flight_q;
	logic                 rec_q;
	logic [TIME_BITS-1:0] begin_q;
	logic                 out_valid_q;

	// item and divider registers
	mode_t                mode_q;
	logic [15:0]          bytes_q;
	logic [TIME_BITS-1:0] sent_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CNT_W-1:0]     quo_q;
	logic [CNT_W:0]       rem_q;
	logic [CNT_W-1:0]     dvs_q;

	logic                 old_pkt;
	logic [CNT_W:0]       flight_sum;
	logic [CNT_W-1:0]     flight_add;
	logic [CNT_W-1:0]     flight_drop;
	logic [CNT_W:0]       win_sum;
	logic [CNT_W-1:0]     win_add;
	logic [CNT_W:0]       grow_sum;
	logic [CNT_W-1:0]     win_grow;
	logic [CNT_W-1:0]     half;
	logic [CNT_W-1:0]     min32;
	logic [CNT_W-1:0]     loss_lim;
	logic [CNT_W-1:0]     prod;
	logic [CNT_W:0]       rem_sh;
	logic                 rem_ge;

	assign old_pkt     = rec_q && (sent_q <= begin_q);
	assign flight_sum  = {1'b0, flight_q} + {{(CNT_W-15){1'b0}}, bytes_q};
	assign flight_add  = flight_sum[CNT_W] ? '1 : flight_sum[CNT_W-1:0];
	assign flight_drop = (flight_q > CNT_W'(bytes_q)) ? flight_q - CNT_W'(bytes_q) : '0;
	assign win_sum     = {1'b0, win_q} + {{(CNT_W-15){1'b0}}, bytes_q};
	assign win_add     = win_sum[CNT_W] ? '1 : win_sum[CNT_W-1:0];
	assign grow_sum    = {1'b0, win_q} + {1'b0, quo_q};
	assign win_grow    = grow_sum[CNT_W] ? '1 : grow_sum[CNT_W-1:0];
	assign half        = {1'b0, win_q[CNT_W-1:1]};
	assign min32       = CNT_W'(min_q);
	assign loss_lim    = (half > min32) ? half : min32;
	assign prod        = CNT_W'(md_q) * CNT_W'(bytes_q);
	assign rem_sh      = {rem_q[CNT_W-1:0], quo_q[CNT_W-1]};
	assign rem_ge      = rem_sh >= {1'b0, dvs_q};

	assign sts.need_div = (mode_q == MODE_ACKED) && !old_pkt && !(win_q < lim_q);
	assign sts.out_free = !out_valid_q || !out_stall;
	assign out_valid    = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			md_q        <= MD_RESET;
			min_q       <= MW_RESET;
			win_q       <= WIN_RESET;
			lim_q       <= '1;
			flight_q    <= '0;
			rec_q       <= 1'b0;
			begin_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (wr_en) begin
				case (wr_index)
					REG_DGRAM_SIZE: begin
						md_q  <= wr_data[MD_W-1:0];
						win_q <= CNT_W'(wr_data[MD_W-1:0]) * INIT_DGRAMS;
					end
					REG_WIN_FLOOR: begin
						min_q <= wr_data[MW_W-1:0];
					end
					default: begin
					end
				endcase
			end else if (cmd.exec) begin
				case (mode_q)
					MODE_SENT: begin
						flight_q <= flight_add;
					end
					MODE_ACKED: begin
						flight_q <= flight_drop;
						if (!old_pkt) begin
							rec_q <= 1'b0;
							if (win_q < lim_q) begin
								win_q <= win_add;
							end
						end
					end
					MODE_LOST: begin
						flight_q <= flight_drop;
						if (!old_pkt) begin
							rec_q   <= 1'b1;
							begin_q <= now_q;
							lim_q   <= loss_lim;
							win_q   <= loss_lim;
						end
					end
					MODE_PERSIST: begin
						win_q <= min32;
						if (lim_q < min32) begin
							lim_q <= min32;
						end
						rec_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end else if (cmd.grow) begin
				win_q <= win_grow;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q  <= mode_t'(mode);
			bytes_q <= bytes;
			sent_q  <= sent_time;
			now_q   <= now_time;
		end
		// restoring divide, one quotient bit per cycle
		if (cmd.exec) begin
			quo_q <= prod;
			rem_q <= '0;
			dvs_q <= (win_q == '0) ? CNT_W'(1) : win_q;
		end else if (cmd.step) begin
			quo_q <= {quo_q[CNT_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sh - {1'b0, dvs_q} : rem_sh;
		end
		if (cmd.emit) begin
			window_bytes    <= win_q;
			threshold_bytes <= lim_q;
			in_flight_bytes <= flight_q;
			recovering      <= rec_q;
		end
	end

endmodule
`default_nettype wire
